// ===== hw/rtl/sfpd_pkg.sv =====
// Shared types and defaults for the signed fixed-point divider.
package sfpd_pkg;

   localparam int DATA_WIDTH_DEF = 64;
   localparam int FRAC_BITS_DEF  = 30;

   // Per-stage control that travels down the cell chain with each transaction.
   typedef struct packed {
      logic valid;
      logic positive;
      logic zero;
      logic hi_ge;
   } sfpd_ctl_type;

endpackage

// ===== hw/rtl/sfpd_req_if.sv =====
// Request channel: dividend and divisor with valid/ready handshake.
interface sfpd_req_if #(
   parameter int DATA_WIDTH = 64
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend;
   logic signed [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// ===== hw/rtl/sfpd_rsp_if.sv =====
// Response channel: quotient and status flags with valid/ready handshake.
interface sfpd_rsp_if #(
   parameter int DATA_WIDTH = 64
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic                         divide_by_zero;
   logic                         overflow;

   modport source (output valid, output quotient, output divide_by_zero, output overflow,
                   input ready);
   modport sink   (input valid, input quotient, input divide_by_zero, input overflow,
                   output ready);
endinterface

// ===== hw/rtl/sfpd_prep.sv =====
// Input stage: operand magnitudes, widened dividend and range check.
module sfpd_prep
   import sfpd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   sfpd_req_if.sink              req_ch,
   output sfpd_ctl_type          ctl_out,
   output logic [DATA_WIDTH-1:0] rem_out,
   output logic [DATA_WIDTH-1:0] lo_out,
   output logic [DATA_WIDTH-1:0] q_out,
   output logic [DATA_WIDTH-1:0] dmag_out
);

   logic [DATA_WIDTH-1:0]   a_u;
   logic [DATA_WIDTH-1:0]   d_u;
   logic                    a_neg;
   logic                    d_neg;
   logic [DATA_WIDTH-1:0]   amag;
   logic [DATA_WIDTH-1:0]   dmag;
   logic [2*DATA_WIDTH-1:0] wide;
   logic [DATA_WIDTH-1:0]   hi;
   sfpd_ctl_type            ctl_in;
   sfpd_ctl_type            ctl_ff;
   logic [DATA_WIDTH-1:0]   rem_ff;
   logic [DATA_WIDTH-1:0]   lo_ff;
   logic [DATA_WIDTH-1:0]   dmag_ff;

   assign req_ch.ready = enable && !reset;

   always_comb begin
      a_u   = req_ch.dividend;
      d_u   = req_ch.divisor;
      a_neg = a_u[DATA_WIDTH-1];
      d_neg = d_u[DATA_WIDTH-1];
      amag  = a_neg ? (DATA_WIDTH'(0) - a_u) : a_u;
      dmag  = d_neg ? (DATA_WIDTH'(0) - d_u) : d_u;
      wide  = {{DATA_WIDTH{1'b0}}, amag} << FRAC_BITS;
      hi    = wide[2*DATA_WIDTH-1:DATA_WIDTH];
      ctl_in.valid    = req_ch.valid;
      ctl_in.positive = (a_neg == d_neg);
      ctl_in.zero     = (dmag == '0);
      ctl_in.hi_ge    = (hi >= dmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= hi;
         lo_ff   <= wide[DATA_WIDTH-1:0];
         dmag_ff <= dmag;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign lo_out   = lo_ff;
   assign q_out    = '0;
   assign dmag_out = dmag_ff;

endmodule

// ===== hw/rtl/sfpd_cell.sv =====
// One restoring shift-subtract step of the divider chain.
module sfpd_cell
   import sfpd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  sfpd_ctl_type          ctl_in_d,
   input  logic [DATA_WIDTH-1:0] rem_in_d,
   input  logic [DATA_WIDTH-1:0] lo_in_d,
   input  logic [DATA_WIDTH-1:0] q_in_d,
   input  logic [DATA_WIDTH-1:0] dmag_in_d,
   output sfpd_ctl_type          ctl_out,
   output logic [DATA_WIDTH-1:0] rem_out,
   output logic [DATA_WIDTH-1:0] lo_out,
   output logic [DATA_WIDTH-1:0] q_out,
   output logic [DATA_WIDTH-1:0] dmag_out
);

   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;
   sfpd_ctl_type          ctl_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] lo_ff;
   logic [DATA_WIDTH-1:0] q_ff;
   logic [DATA_WIDTH-1:0] dmag_ff;

   always_comb begin
      shifted = {rem_in_d[DATA_WIDTH-2:0], lo_in_d[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, dmag_in_d};
      // subtract when the dropped top bit is set or no borrow occurs
      take    = rem_in_d[DATA_WIDTH-1] || !diff[DATA_WIDTH];
      rem_in  = take ? diff[DATA_WIDTH-1:0] : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         lo_ff   <= {lo_in_d[DATA_WIDTH-2:0], 1'b0};
         q_ff    <= {q_in_d[DATA_WIDTH-2:0], take};
         dmag_ff <= dmag_in_d;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign lo_out   = lo_ff;
   assign q_out    = q_ff;
   assign dmag_out = dmag_ff;

endmodule

// ===== hw/rtl/sfpd_out.sv =====
// Output stage: sign correction, overflow flag, output register and skid buffer.
module sfpd_out
   import sfpd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfpd_ctl_type          ctl_in_d,
   input  logic [DATA_WIDTH-1:0] q_in_d,
   output logic                  enable,
   sfpd_rsp_if.source            rsp_ch
);

   logic [DATA_WIDTH-1:0] res_q;
   logic                  res_ovf;
   logic                  load;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic [DATA_WIDTH-1:0] out_q_ff;
   logic [DATA_WIDTH-1:0] out_q_in;
   logic                  out_zero_ff;
   logic                  out_zero_in;
   logic                  out_ovf_ff;
   logic                  out_ovf_in;
   logic [DATA_WIDTH-1:0] skid_q_ff;
   logic [DATA_WIDTH-1:0] skid_q_in;
   logic                  skid_zero_ff;
   logic                  skid_zero_in;
   logic                  skid_ovf_ff;
   logic                  skid_ovf_in;

   assign enable = !skid_valid_ff;
   assign load   = ctl_in_d.valid && enable;

   always_comb begin
      res_q = ctl_in_d.positive ? q_in_d : (DATA_WIDTH'(0) - q_in_d);
      priority if (ctl_in_d.zero) begin
         res_ovf = 1'b0;
      end else if (ctl_in_d.hi_ge) begin
         res_ovf = 1'b1;
      end else if (ctl_in_d.positive) begin
         res_ovf = q_in_d[DATA_WIDTH-1];
      end else begin
         res_ovf = q_in_d[DATA_WIDTH-1] && (|q_in_d[DATA_WIDTH-2:0]);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_q_in      = out_q_ff;
      out_zero_in   = out_zero_ff;
      out_ovf_in    = out_ovf_ff;
      skid_q_in     = skid_q_ff;
      skid_zero_in  = skid_zero_ff;
      skid_ovf_in   = skid_ovf_ff;
      priority if (skid_valid_ff) begin
         // drain the skid entry once the output is taken
         if (rsp_ch.ready) begin
            out_q_in      = skid_q_ff;
            out_zero_in   = skid_zero_ff;
            out_ovf_in    = skid_ovf_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!out_valid_ff || rsp_ch.ready) begin
            out_valid_in = 1'b1;
            out_q_in     = res_q;
            out_zero_in  = ctl_in_d.zero;
            out_ovf_in   = res_ovf;
         end else begin
            skid_valid_in = 1'b1;
            skid_q_in     = res_q;
            skid_zero_in  = ctl_in_d.zero;
            skid_ovf_in   = res_ovf;
         end
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_q_ff     <= out_q_in;
      out_zero_ff  <= out_zero_in;
      out_ovf_ff   <= out_ovf_in;
      skid_q_ff    <= skid_q_in;
      skid_zero_ff <= skid_zero_in;
      skid_ovf_ff  <= skid_ovf_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.quotient       = out_q_ff;
   assign rsp_ch.divide_by_zero = out_zero_ff;
   assign rsp_ch.overflow       = out_ovf_ff;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a valid output entry");

   a_zero_no_ovf: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_zero_ff |-> !out_ovf_ff)
      else $error("divide by zero reported together with overflow");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ch.ready |=> skid_valid_ff && !enable)
      else $error("skid entry dropped while the output stalled");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(load) && $past(out_valid_ff) && !$past(rsp_ch.ready))
      else $error("skid entry filled without a stalled output");
`endif

endmodule

// ===== hw/rtl/signed_fixed_point_divider_top.sv =====
// Pipeline: the input stage loads at the accepting edge, then one cell per quotient bit,
// then one output register.
// Throughput: one transaction per cycle; the chain of DATA_WIDTH cells advances together
// and halts only when both the output register and its skid entry are full.
// Reset: synchronous, active high; clears all valid bits, req ready is low during reset.
// Top level of the signed fixed-point divider.
module signed_fixed_point_divider_top
   import sfpd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   sfpd_req_if.sink   req_ch,
   sfpd_rsp_if.source rsp_ch
);

   logic                  enable;
   sfpd_ctl_type          ctl_w  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_w  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] lo_w   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] q_w    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dmag_w [0:DATA_WIDTH];

   sfpd_prep #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .req_ch   (req_ch),
      .ctl_out  (ctl_w[0]),
      .rem_out  (rem_w[0]),
      .lo_out   (lo_w[0]),
      .q_out    (q_w[0]),
      .dmag_out (dmag_w[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sfpd_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .ctl_in_d  (ctl_w[i]),
         .rem_in_d  (rem_w[i]),
         .lo_in_d   (lo_w[i]),
         .q_in_d    (q_w[i]),
         .dmag_in_d (dmag_w[i]),
         .ctl_out   (ctl_w[i+1]),
         .rem_out   (rem_w[i+1]),
         .lo_out    (lo_w[i+1]),
         .q_out     (q_w[i+1]),
         .dmag_out  (dmag_w[i+1])
      );
   end

   sfpd_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .ctl_in_d (ctl_w[DATA_WIDTH]),
      .q_in_d   (q_w[DATA_WIDTH]),
      .enable   (enable),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== tb/signed_fixed_point_divider_top_test.sv =====
// Self-checking testbench for the signed Q33.30 fixed-point divider.
`timescale 1ns / 1ps

module signed_fixed_point_divider_top_test;
   import sfpd_pkg::*;

   localparam int DW              = DATA_WIDTH_DEF;
   localparam int FB              = FRAC_BITS_DEF;
   localparam int RANDOM_PER_PASS = 600;
   localparam int DRAIN_CYCLES    = DW + 10;
   localparam int CYCLE_LIMIT     = 200000;

   localparam logic [DW-1:0] Q_MIN      = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] Q_MAX      = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] ALL_ONES   = {DW{1'b1}};
   localparam logic [DW-1:0] FIX_ONE    = 64'h0000_0000_4000_0000;
   localparam logic [DW-1:0] FIX_NEG1   = 64'hFFFF_FFFF_C000_0000;
   localparam logic [DW-1:0] FIX_SIX    = 64'h0000_0001_8000_0000;
   localparam logic [DW-1:0] FIX_NEG2   = 64'hFFFF_FFFF_8000_0000;
   localparam logic [DW-1:0] FIX_NEG3   = 64'hFFFF_FFFF_4000_0000;
   localparam logic [DW-1:0] ALT_HIGH   = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [DW-1:0] ALT_LOW    = 64'h5555_5555_5555_5555;
   localparam logic [DW-1:0] POW33      = 64'h0000_0002_0000_0000;
   localparam logic [DW-1:0] NEG_POW33  = 64'hFFFF_FFFE_0000_0000;
   localparam logic [DW-1:0] POW34      = 64'h0000_0004_0000_0000;
   localparam logic [DW-1:0] BELOW34    = 64'h0000_0003_FFFF_FFFF;

   typedef struct packed {
      logic [DW-1:0] quotient;
      logic          divide_by_zero;
      logic          overflow;
   } divide_result_type;

   typedef struct packed {
      logic [DW-1:0]     dividend;
      logic [DW-1:0]     divisor;
      bit                known;
      divide_result_type result;
   } directed_row_type;

   localparam int NUM_DIRECTED = 24;

   // Rows with known set carry a result read straight off the spec; the rest use the predictor.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{64'd0,     FIX_ONE,  1'b1, '{64'd0,    1'b0, 1'b0}},
      '{FIX_ONE,   FIX_ONE,  1'b1, '{FIX_ONE,  1'b0, 1'b0}},
      '{FIX_NEG1,  FIX_ONE,  1'b1, '{FIX_NEG1, 1'b0, 1'b0}},
      '{FIX_SIX,   FIX_NEG2, 1'b1, '{FIX_NEG3, 1'b0, 1'b0}},
      '{64'd5,     64'd0,    1'b1, '{ALL_ONES, 1'b1, 1'b0}},
      '{-64'd5,    64'd0,    1'b1, '{64'd1,    1'b1, 1'b0}},
      '{64'd0,     64'd0,    1'b1, '{ALL_ONES, 1'b1, 1'b0}},
      '{Q_MIN,     64'd0,    1'b1, '{64'd1,    1'b1, 1'b0}},
      '{Q_MAX,     Q_MAX,    1'b1, '{FIX_ONE,  1'b0, 1'b0}},
      '{Q_MIN,     Q_MIN,    1'b1, '{FIX_ONE,  1'b0, 1'b0}},
      '{Q_MAX,     64'd1,    1'b0, '{64'd0,    1'b0, 1'b0}},
      '{Q_MIN,     ALL_ONES, 1'b0, '{64'd0,    1'b0, 1'b0}},
      '{Q_MIN,     64'd1,    1'b0, '{64'd0,    1'b0, 1'b0}},
      '{Q_MAX,     ALL_ONES, 1'b0, '{64'd0,    1'b0, 1'b0}},
      '{64'd1,     Q_MAX,    1'b1, '{64'd0,    1'b0, 1'b0}},
      '{ALL_ONES,  Q_MAX,    1'b1, '{64'd0,    1'b0, 1'b0}},
      '{POW33,     64'd1,    1'b1, '{Q_MIN,    1'b0, 1'b1}},
      '{NEG_POW33, 64'd1,    1'b1, '{Q_MIN,    1'b0, 1'b0}},
      '{POW34,     64'd1,    1'b0, '{64'd0,    1'b0, 1'b0}},
      '{ALT_HIGH,  ALT_LOW,  1'b0, '{64'd0,    1'b0, 1'b0}},
      '{ALT_LOW,   ALT_HIGH, 1'b0, '{64'd0,    1'b0, 1'b0}},
      '{ALL_ONES,  ALL_ONES, 1'b1, '{FIX_ONE,  1'b0, 1'b0}},
      '{Q_MAX,     Q_MIN,    1'b0, '{64'd0,    1'b0, 1'b0}},
      '{BELOW34,   64'd1,    1'b0, '{64'd0,    1'b0, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_accept = 1'b0;

   logic              item_known = 1'b0;
   divide_result_type item_result = '0;

   int send_idle_pct = 26;
   int rsp_idle_pct  = 77;
   int cycle_count   = 0;
   int mismatch_count = 0;
   int checked_count  = 0;
   int zero_div_count = 0;
   int overflow_count = 0;

   divide_result_type pending_quotients [$];

   sfpd_req_if #(.DATA_WIDTH(DW)) req_ch ();
   sfpd_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   assign rsp_ch.ready = rsp_accept;

   signed_fixed_point_divider_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   // Restoring division of the widened dividend magnitude, then sign correction.
   function automatic divide_result_type divide_q30(input logic [DW-1:0] num,
                                                   input logic [DW-1:0] den);
      logic [DW-1:0]     num_mag;
      logic [DW-1:0]     den_mag;
      logic [DW-1:0]     upper;
      logic [DW-1:0]     part;
      logic [DW-1:0]     quo;
      logic [2*DW-1:0]   wide;
      logic              same_sign;
      logic              carry_out;
      divide_result_type res;
      num_mag   = num[DW-1] ? -num : num;
      den_mag   = den[DW-1] ? -den : den;
      same_sign = (num[DW-1] == den[DW-1]);
      wide      = {{DW{1'b0}}, num_mag} << FB;
      upper     = wide[2*DW-1:DW];
      part      = upper;
      quo       = '0;
      for (int i = DW - 1; i >= 0; i--) begin
         carry_out = part[DW-1];
         part = {part[DW-2:0], wide[i]};
         // a bit shifted out of the remainder forces the subtraction
         if (carry_out || part >= den_mag) begin
            part   = part - den_mag;
            quo[i] = 1'b1;
         end
      end
      res.divide_by_zero = (den_mag == '0);
      if (res.divide_by_zero)
         res.overflow = 1'b0;
      else if (upper >= den_mag)
         res.overflow = 1'b1;
      else if (same_sign)
         res.overflow = quo[DW-1];
      else
         res.overflow = (quo > Q_MIN);
      res.quotient = same_sign ? quo : -quo;
      return res;
   endfunction

   function automatic logic [DW-1:0] random_operand();
      logic [DW-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4, 5: begin
            v = v >> $urandom_range(0, DW - 1);
            if ($urandom_range(0, 1) != 0)
               v = -v;
         end
         6: begin
            case ($urandom_range(0, 4))
               0: v = Q_MIN;
               1: v = Q_MAX;
               2: v = '0;
               3: v = ALL_ONES;
               default: v = 64'd1;
            endcase
         end
         7, 8: begin
            // small fixed-point magnitudes with a random fraction
            v = ({{(DW-32){1'b0}}, $urandom_range(0, 4095)} << FB)
                | {{(DW-FB){1'b0}}, v[FB-1:0]};
            if ($urandom_range(0, 1) != 0)
               v = -v;
         end
         default: begin
            v = ({{(DW-1){1'b0}}, 1'b1} << $urandom_range(0, DW - 1))
                + {{(DW-2){1'b0}}, 2'($urandom_range(0, 2))} - 64'd1;
         end
      endcase
      return v;
   endfunction

   task automatic send_division(input logic [DW-1:0] num, input logic [DW-1:0] den,
                                input bit known, input divide_result_type known_result);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.dividend <= num;
      req_ch.divisor  <= den;
      item_known      <= known;
      item_result     <= known_result;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send_random(input int count);
      logic [DW-1:0] den;
      for (int n = 0; n < count; n++) begin
         den = ($urandom_range(0, 99) < 3) ? '0 : random_operand();
         send_division(random_operand(), den, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_accept <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("signed_fixed_point_divider_top test failed");
         $finish;
      end
   end

   // Record each accepted transaction and check each returned one against the oldest.
   always @(posedge clock) begin
      divide_result_type want;
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            pending_quotients.push_back(item_known ? item_result
                                        : divide_q30(req_ch.dividend, req_ch.divisor));
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_quotients.size() == 0) begin
               $error("response transaction with none outstanding");
               mismatch_count++;
            end else begin
               want = pending_quotients.pop_front();
               checked_count++;
               if (want.divide_by_zero)
                  zero_div_count++;
               if (want.overflow)
                  overflow_count++;
               if (rsp_ch.quotient !== want.quotient) begin
                  $error("quotient: expected %h, got %h", want.quotient, rsp_ch.quotient);
                  mismatch_count++;
               end
               if (rsp_ch.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero: expected %b, got %b", want.divide_by_zero,
                         rsp_ch.divide_by_zero);
                  mismatch_count++;
               end
               if (rsp_ch.overflow !== want.overflow) begin
                  $error("overflow: expected %b, got %b", want.overflow, rsp_ch.overflow);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.dividend = '0;
      req_ch.divisor  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender sparse gaps, receiver mostly stalled
      send_idle_pct = 26;
      rsp_idle_pct  = 77;
      foreach (directed_rows[r])
         send_division(directed_rows[r].dividend, directed_rows[r].divisor,
                       directed_rows[r].known, directed_rows[r].result);
      // hold off until the pipeline has emptied
      req_ch.valid <= 1'b0;
      while (pending_quotients.size() != 0) @(posedge clock);
      send_random(RANDOM_PER_PASS);

      send_idle_pct = 77;
      rsp_idle_pct  = 26;
      send_random(RANDOM_PER_PASS);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      send_random(RANDOM_PER_PASS);

      req_ch.valid <= 1'b0;
      while (pending_quotients.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d divisions (%0d by zero, %0d overflowing) under three idle mixes.",
               checked_count, zero_div_count, overflow_count);
      if (mismatch_count == 0 && pending_quotients.size() == 0)
         $display("signed_fixed_point_divider_top test passed");
      else
         $display("signed_fixed_point_divider_top test failed");
      $finish;
   end

endmodule
